@@ sv/bvwr_pkg.sv @@
package bvwr_pkg;

  // Configuration register indexes
  typedef enum logic [2:0] {
    REG_TOLERANCE      = 3'd0,
    REG_DUTY_TOP       = 3'd1,
    REG_VOLTAGE_MIN    = 3'd2,
    REG_VOLTAGE_MAX    = 3'd3,
    REG_HOLDOFF_RELOAD = 3'd4
  } bvwr_reg_e;

  typedef enum logic [1:0] {
    LAMP_LOW  = 2'd0,
    LAMP_OK   = 2'd1,
    LAMP_HIGH = 2'd2
  } bvwr_lamp_e;

  localparam logic [4:0] TOLERANCE_RST      = 5'd2;
  localparam logic [7:0] DUTY_TOP_RST       = 8'd255;
  localparam logic [7:0] VOLTAGE_MIN_RST    = 8'd20;
  localparam logic [7:0] VOLTAGE_MAX_RST    = 8'd240;
  localparam logic [4:0] HOLDOFF_RELOAD_RST = 5'd20;

  localparam logic [7:0] SET_VOLTAGE_RST = 8'd60;
  localparam logic [4:0] HOLDOFF_RST     = 5'd10;
  localparam logic [7:0] DUTY_LEVEL_RST  = 8'd1;

  // floor(x/197) = (x * ceil(2^26/197)) >> 26, exact for x below 392449
  localparam logic [18:0] RECIP_197   = 19'd340655;
  localparam int unsigned RECIP_SHIFT = 26;

  localparam logic [10:0] CODE_SPAN = 11'd1024;
  localparam logic [9:0]  CODE_MAX  = 10'd1023;

endpackage

@@ sv/bvwr_if.sv @@
interface bvwr_in_if;
  logic       valid;
  logic       ready;
  logic [9:0] adc_sample;
  logic       down_pressed;
  logic       up_pressed;

  modport source (output valid, output adc_sample, output down_pressed, output up_pressed,
                  input ready);
  modport sink (input valid, input adc_sample, input down_pressed, input up_pressed,
                output ready);
endinterface

interface bvwr_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] duty;
  logic [1:0] lamp;
  logic [7:0] set_voltage_out;
  logic [9:0] target_code;

  modport source (output valid, output duty, output lamp, output set_voltage_out,
                  output target_code, input ready);
  modport sink (input valid, input duty, input lamp, input set_voltage_out,
                input target_code, output ready);
endinterface

interface bvwr_cfg_if;
  logic       valid;
  logic       ready;
  logic [2:0] index;
  logic [7:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

@@ sv/boost_voltage_window_regulator.sv @@
// An input transfer passes through the input register and then the result register before
// its result can be transferred. Throughput: one item per cycle while the output is not
// stalled; the set voltage, hold-off and duty update in one pass through the button logic,
// the reciprocal multiply for the target and the window compare.
// Reset (rst_ni low, asynchronous): both stages empty, configuration and state take
// their documented reset values. No clearing pass is needed.
module boost_voltage_window_regulator
  import bvwr_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  bvwr_in_if.sink      in_i,
  bvwr_out_if.source   out_o,
  bvwr_cfg_if.sink     cfg_i
);

  logic [4:0] tolerance_q;
  logic [7:0] duty_top_q;
  logic [7:0] voltage_min_q;
  logic [7:0] voltage_max_q;
  logic [4:0] holdoff_reload_q;

  logic [7:0] set_voltage_q, set_voltage_d;
  logic [4:0] down_hold_q, down_hold_d;
  logic [4:0] up_hold_q, up_hold_d;
  logic [7:0] duty_q, duty_d;

  logic       in_valid_q;
  logic [9:0] adc_q;
  logic       down_q;
  logic       up_q;

  logic       out_valid_q;
  logic [7:0] out_duty_q;
  logic [1:0] out_lamp_q;
  logic [7:0] out_volt_q;
  logic [9:0] out_code_q;

  logic        advance;
  logic [7:0]  volt_mid;
  logic [17:0] volt_x800;
  logic [36:0] recip_prod;
  logic [10:0] quot;
  logic [10:0] code_lim;
  logic [10:0] target;
  logic signed [12:0] win_lo;
  logic [11:0] win_hi;
  logic [1:0]  lamp_d;
  logic [9:0]  code_d;

  assign advance     = in_valid_q && (!out_valid_q || out_o.ready);
  assign in_i.ready  = !in_valid_q || !out_valid_q || out_o.ready;
  assign cfg_i.ready = 1'b1;

  // Configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tolerance_q      <= TOLERANCE_RST;
      duty_top_q       <= DUTY_TOP_RST;
      voltage_min_q    <= VOLTAGE_MIN_RST;
      voltage_max_q    <= VOLTAGE_MAX_RST;
      holdoff_reload_q <= HOLDOFF_RELOAD_RST;
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        REG_TOLERANCE:      tolerance_q      <= cfg_i.data[4:0];
        REG_DUTY_TOP:       duty_top_q       <= cfg_i.data;
        REG_VOLTAGE_MIN:    voltage_min_q    <= cfg_i.data;
        REG_VOLTAGE_MAX:    voltage_max_q    <= cfg_i.data;
        REG_HOLDOFF_RELOAD: holdoff_reload_q <= cfg_i.data[4:0];
        default: ;
      endcase
    end
  end

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      in_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      adc_q  <= in_i.adc_sample;
      down_q <= in_i.down_pressed;
      up_q   <= in_i.up_pressed;
    end
  end

  always_comb begin
    down_hold_d = down_hold_q;
    up_hold_d   = up_hold_q;
    volt_mid    = set_voltage_q;

    // Down button first, then up on the updated voltage
    if (down_q) begin
      if (down_hold_q == 5'd0 && set_voltage_q > voltage_min_q) begin
        down_hold_d = holdoff_reload_q;
        volt_mid    = set_voltage_q - 8'd1;
      end
    end else if (down_hold_q != 5'd0) begin
      down_hold_d = down_hold_q - 5'd1;
    end

    set_voltage_d = volt_mid;
    if (up_q) begin
      if (up_hold_q == 5'd0 && volt_mid < voltage_max_q) begin
        up_hold_d     = holdoff_reload_q;
        set_voltage_d = volt_mid + 8'd1;
      end
    end else if (up_hold_q != 5'd0) begin
      up_hold_d = up_hold_q - 5'd1;
    end

    // voltage * 800 as shifted adds, then divide by 197 via reciprocal
    volt_x800  = {1'b0, set_voltage_d, 9'd0} + {2'b0, set_voltage_d, 8'd0}
               + {5'b0, set_voltage_d, 5'd0};
    recip_prod = {19'd0, volt_x800} * {18'd0, RECIP_197};
    quot       = recip_prod[RECIP_SHIFT +: 11];
    code_lim   = CODE_SPAN - {6'd0, tolerance_q};
    target     = (quot >= code_lim) ? code_lim : quot;
    code_d     = (target > {1'b0, CODE_MAX}) ? CODE_MAX : target[9:0];

    win_lo = $signed({2'b0, target}) - $signed({8'd0, tolerance_q});
    win_hi = {1'b0, target} + {7'd0, tolerance_q};

    duty_d = duty_q;
    if ($signed({3'b0, adc_q}) < win_lo) begin
      lamp_d = LAMP_LOW;
      if ({2'b0, duty_q} + 10'd2 < {2'b0, duty_top_q}) begin
        duty_d = duty_q + 8'd1;
      end
    end else if ({2'b0, adc_q} <= win_hi) begin
      lamp_d = LAMP_OK;
    end else begin
      lamp_d = LAMP_HIGH;
      if (duty_q > 8'd1) begin
        duty_d = duty_q - 8'd1;
      end
    end
  end

  // State and result valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      set_voltage_q <= SET_VOLTAGE_RST;
      down_hold_q   <= HOLDOFF_RST;
      up_hold_q     <= HOLDOFF_RST;
      duty_q        <= DUTY_LEVEL_RST;
      out_valid_q   <= 1'b0;
    end else begin
      if (advance) begin
        set_voltage_q <= set_voltage_d;
        down_hold_q   <= down_hold_d;
        up_hold_q     <= up_hold_d;
        duty_q        <= duty_d;
        out_valid_q   <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_duty_q <= duty_d;
      out_lamp_q <= lamp_d;
      out_volt_q <= set_voltage_d;
      out_code_q <= code_d;
    end
  end

  assign out_o.valid           = out_valid_q;
  assign out_o.duty            = out_duty_q;
  assign out_o.lamp            = out_lamp_q;
  assign out_o.set_voltage_out = out_volt_q;
  assign out_o.target_code     = out_code_q;

endmodule

@@ sv/bvwr_checker.sv @@
module bvwr_checker
  import bvwr_pkg::*;
(
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_ready_i,
  input logic       out_valid_i,
  input logic       out_ready_i,
  input logic [7:0] duty_i,
  input logic [1:0] lamp_i,
  input logic [7:0] volt_i,
  input logic [9:0] code_i
);

  // Hold a stalled result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(duty_i) && $stable(lamp_i)
      && $stable(volt_i) && $stable(code_i))
    else $error("stalled result changed");

  // Input only stalls behind a full, stalled result stage
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_i |-> out_valid_i && !out_ready_i)
    else $error("input stalled without output back-pressure");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> (lamp_i == LAMP_LOW || lamp_i == LAMP_OK || lamp_i == LAMP_HIGH))
    else $error("lamp code out of range");

  // Duty starts at one and never falls below it
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> duty_i != 8'd0)
    else $error("duty reached zero");

endmodule

bind boost_voltage_window_regulator bvwr_checker u_bvwr_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_ready_i  (in_i.ready),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .duty_i      (out_o.duty),
  .lamp_i      (out_o.lamp),
  .volt_i      (out_o.set_voltage_out),
  .code_i      (out_o.target_code)
);

@@ tb/tb_boost_voltage_window_regulator.sv @@
module tb_boost_voltage_window_regulator;
  import bvwr_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int PIPE_LATENCY = 2;
  localparam int LONG_STALL   = 300;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int VOLT_NUM     = 800;
  localparam int VOLT_DEN     = 197;

  typedef struct packed {
    logic [7:0] duty;
    bvwr_lamp_e lamp;
    logic [7:0] set_voltage;
    logic [9:0] target;
  } regulator_result_t;

  typedef enum {MIX_BALANCED, MIX_RISE, MIX_FALL, MIX_NOISE} stim_mix_e;
  typedef enum {SINK_OPEN, SINK_LIGHT, SINK_HALF, SINK_TOGGLE} sink_pace_e;

  logic clk_i;
  logic rst_ni;

  bvwr_in_if  in_if ();
  bvwr_out_if out_if ();
  bvwr_cfg_if cfg_if ();

  boost_voltage_window_regulator dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if),
    .cfg_i  (cfg_if)
  );

  // predicted configuration and state
  logic [4:0] cfg_tol;
  logic [7:0] cfg_top;
  logic [7:0] cfg_vmin;
  logic [7:0] cfg_vmax;
  logic [4:0] cfg_reload;
  logic [7:0] volt_set;
  logic [4:0] down_wait;
  logic [4:0] up_wait;
  logic [7:0] duty_lvl;

  regulator_result_t expected_results[$];

  int  failures;
  int  steps_sent;
  int  results_checked;
  int  settings_loaded;
  int  lamp_seen[3];
  int  burst_left;
  bit  gaps_on;
  bit  down_held;
  bit  up_held;
  int  stall_requests;
  int  cycle_count;

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  function automatic int target_now();
    int aim;
    aim = (int'(volt_set) * VOLT_NUM) / VOLT_DEN;
    if (aim >= int'(CODE_SPAN) - int'(cfg_tol)) aim = int'(CODE_SPAN) - int'(cfg_tol);
    return aim;
  endfunction

  function automatic regulator_result_t step_regulator(logic [9:0] sample, logic dn,
                                                       logic upb);
    regulator_result_t res;
    int aim;
    int tol;
    if (dn) begin
      if (down_wait == 5'd0 && volt_set > cfg_vmin) begin
        down_wait = cfg_reload;
        volt_set  = volt_set - 8'd1;
      end
    end else if (down_wait != 5'd0) begin
      down_wait = down_wait - 5'd1;
    end
    if (upb) begin
      if (up_wait == 5'd0 && volt_set < cfg_vmax) begin
        up_wait  = cfg_reload;
        volt_set = volt_set + 8'd1;
      end
    end else if (up_wait != 5'd0) begin
      up_wait = up_wait - 5'd1;
    end
    aim = target_now();
    tol = int'(cfg_tol);
    // the lower bound may go negative; compare as signed
    if (int'(sample) < aim - tol) begin
      res.lamp = LAMP_LOW;
      if (int'(duty_lvl) < int'(cfg_top) - 2) duty_lvl = duty_lvl + 8'd1;
    end else if (int'(sample) <= aim + tol) begin
      res.lamp = LAMP_OK;
    end else begin
      res.lamp = LAMP_HIGH;
      if (duty_lvl > 8'd1) duty_lvl = duty_lvl - 8'd1;
    end
    res.duty        = duty_lvl;
    res.set_voltage = volt_set;
    res.target      = (aim > int'(CODE_MAX)) ? CODE_MAX : 10'(aim);
    return res;
  endfunction

  function automatic logic [9:0] pick_sample(stim_mix_e mix);
    int aim;
    int lo;
    int hi;
    int roll;
    int v;
    aim  = target_now();
    lo   = aim - int'(cfg_tol);
    hi   = aim + int'(cfg_tol);
    roll = int'($urandom_range(0, 99));
    if (mix == MIX_NOISE || roll < 10) return 10'($urandom_range(0, 1023));
    if (roll < 15) return $urandom_range(0, 1) ? 10'd0 : CODE_MAX;
    if ((mix == MIX_RISE && roll < 95) || (mix == MIX_BALANCED && roll < 40)) begin
      if (lo > 0) return 10'($urandom_range(0, lo - 1));
    end else if ((mix == MIX_FALL && roll < 95) || (mix == MIX_BALANCED && roll < 65)) begin
      if (hi < int'(CODE_MAX)) return 10'($urandom_range(hi + 1, 1023));
    end
    // land inside the window or just outside its edges
    v = aim + int'($urandom_range(0, 2 * int'(cfg_tol) + 6)) - int'(cfg_tol) - 3;
    if (v < 0) v = 0;
    if (v > int'(CODE_MAX)) v = int'(CODE_MAX);
    return 10'(v);
  endfunction

  task automatic note_mismatch(string field, int want, int got);
    $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
    failures++;
  endtask

  // result checker
  always @(posedge clk_i) begin
    regulator_result_t want;
    if (rst_ni === 1'b1 && out_if.valid === 1'b1 && out_if.ready === 1'b1) begin
      if (expected_results.size() == 0) begin
        $display("%0t ns: unexpected result, expected none, actual duty %0d lamp %0d volt %0d code %0d",
                 $time, out_if.duty, out_if.lamp, out_if.set_voltage_out, out_if.target_code);
        failures++;
      end else begin
        want = expected_results.pop_front();
        results_checked++;
        lamp_seen[int'(want.lamp)]++;
        if (out_if.duty !== want.duty) note_mismatch("duty", want.duty, out_if.duty);
        if (out_if.lamp !== want.lamp) note_mismatch("lamp", int'(want.lamp), out_if.lamp);
        if (out_if.set_voltage_out !== want.set_voltage)
          note_mismatch("set_voltage_out", want.set_voltage, out_if.set_voltage_out);
        if (out_if.target_code !== want.target)
          note_mismatch("target_code", want.target, out_if.target_code);
      end
    end
  end

  // result side pacing, with a long hold-off on request
  initial begin
    int stall_left;
    int stall_served;
    int pace_left;
    sink_pace_e pace;
    stall_left   = 0;
    stall_served = 0;
    pace_left    = 0;
    pace         = SINK_OPEN;
    out_if.ready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (stall_left != 0) begin
        out_if.ready <= 1'b0;
        stall_left--;
      end else if (stall_served != stall_requests) begin
        stall_served++;
        stall_left = LONG_STALL;
        out_if.ready <= 1'b0;
      end else begin
        if (pace_left == 0) begin
          pace      = sink_pace_e'($urandom_range(0, 3));
          pace_left = $urandom_range(16, 96);
        end else begin
          pace_left--;
        end
        case (pace)
          SINK_OPEN:   out_if.ready <= 1'b1;
          SINK_LIGHT:  out_if.ready <= ($urandom_range(0, 3) != 0);
          SINK_HALF:   out_if.ready <= 1'($urandom_range(0, 1));
          default:     out_if.ready <= !out_if.ready;
        endcase
      end
    end
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("%0t ns: run did not complete within %0d cycles", $time, CYCLE_LIMIT);
    $display("tb: failure");
    $finish;
  end

  task automatic send_step(logic [9:0] sample, logic dn, logic upb);
    in_if.valid        <= 1'b1;
    in_if.adc_sample   <= sample;
    in_if.down_pressed <= dn;
    in_if.up_pressed   <= upb;
    do @(posedge clk_i); while (in_if.ready !== 1'b1);
    expected_results.push_back(step_regulator(sample, dn, upb));
    steps_sent++;
  endtask

  task automatic feed_step(logic [9:0] sample, logic dn, logic upb);
    send_step(sample, dn, upb);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(0, 15);
      if (gaps_on) begin
        in_if.valid <= 1'b0;
        repeat ($urandom_range(1, 8)) @(posedge clk_i);
      end
    end
  endtask

  // hold the input until every expected result is back and the pipe is empty
  task automatic drain_results();
    in_if.valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (PIPE_LATENCY + 1) @(posedge clk_i);
  endtask

  task automatic load_config(logic [4:0] tol, logic [7:0] top, logic [7:0] vmin,
                             logic [7:0] vmax, logic [4:0] reload);
    bvwr_reg_e  regs[5];
    logic [7:0] vals[5];
    drain_results();
    regs = '{REG_TOLERANCE, REG_DUTY_TOP, REG_VOLTAGE_MIN, REG_VOLTAGE_MAX, REG_HOLDOFF_RELOAD};
    vals = '{8'(tol), top, vmin, vmax, 8'(reload)};
    for (int k = 0; k < 5; k++) begin
      cfg_if.valid <= 1'b1;
      cfg_if.index <= regs[k];
      cfg_if.data  <= vals[k];
      do @(posedge clk_i); while (cfg_if.ready !== 1'b1);
    end
    cfg_if.valid <= 1'b0;
    cfg_tol    = tol;
    cfg_top    = top;
    cfg_vmin   = vmin;
    cfg_vmax   = vmax;
    cfg_reload = reload;
    settings_loaded++;
    @(posedge clk_i);
  endtask

  task automatic run_mix(int count, stim_mix_e mix);
    logic dn;
    logic upb;
    for (int n = 0; n < count; n++) begin
      case (mix)
        MIX_RISE: begin
          upb = ($urandom_range(0, 9) != 0);
          dn  = ($urandom_range(0, 29) == 0);
        end
        MIX_FALL: begin
          dn  = ($urandom_range(0, 9) != 0);
          upb = ($urandom_range(0, 29) == 0);
        end
        MIX_NOISE: begin
          dn  = 1'($urandom_range(0, 1));
          upb = 1'($urandom_range(0, 1));
        end
        default: begin
          // buttons are held for runs, so the hold-off counters matter
          if ($urandom_range(0, 5) == 0) down_held = !down_held;
          if ($urandom_range(0, 5) == 0) up_held = !up_held;
          dn  = down_held;
          upb = up_held;
        end
      endcase
      feed_step(pick_sample(mix), dn, upb);
    end
  endtask

  // window edges and both extremes at reset settings
  task automatic test_reset_state();
    int aim;
    int tol;
    aim = target_now();
    tol = int'(cfg_tol);
    feed_step(10'(aim - tol - 1), 1'b0, 1'b0);
    feed_step(10'(aim - tol), 1'b0, 1'b0);
    feed_step(10'(aim + tol), 1'b0, 1'b0);
    feed_step(10'(aim + tol + 1), 1'b0, 1'b0);
    feed_step(10'd0, 1'b0, 1'b0);
    feed_step(CODE_MAX, 1'b0, 1'b0);
  endtask

  task automatic test_buttons_holdoff();
    load_config(TOLERANCE_RST, DUTY_TOP_RST, VOLTAGE_MIN_RST, VOLTAGE_MAX_RST, 5'd0);
    // counters still running: a press does nothing
    feed_step(10'(target_now()), 1'b1, 1'b1);
    repeat (4) feed_step(10'(target_now()), 1'b0, 1'b0);
    feed_step(10'(target_now()), 1'b1, 1'b1);
    feed_step(10'(target_now()), 1'b1, 1'b0);
    feed_step(10'(target_now()), 1'b0, 1'b1);
    load_config(TOLERANCE_RST, DUTY_TOP_RST, VOLTAGE_MIN_RST, VOLTAGE_MAX_RST, 5'd31);
    feed_step(10'(target_now()), 1'b0, 1'b1);
    feed_step(10'(target_now()), 1'b0, 1'b1);
  endtask

  task automatic test_duty_limits();
    load_config(TOLERANCE_RST, 8'd5, VOLTAGE_MIN_RST, VOLTAGE_MAX_RST, HOLDOFF_RELOAD_RST);
    repeat (4) feed_step(10'd0, 1'b0, 1'b0);
    // duty now sits above the period top
    load_config(TOLERANCE_RST, 8'd0, VOLTAGE_MIN_RST, VOLTAGE_MAX_RST, HOLDOFF_RELOAD_RST);
    feed_step(10'd0, 1'b0, 1'b0);
    feed_step(CODE_MAX, 1'b0, 1'b0);
    load_config(TOLERANCE_RST, 8'd2, VOLTAGE_MIN_RST, VOLTAGE_MAX_RST, HOLDOFF_RELOAD_RST);
    feed_step(10'd0, 1'b0, 1'b0);
  endtask

  // drive the set voltage to both ends: clamped target at the top, negative bound at zero
  task automatic test_voltage_sweep();
    load_config(5'd0, 8'd255, 8'd0, 8'd255, 5'd0);
    run_mix(320, MIX_RISE);
    load_config(5'd31, 8'd255, 8'd0, 8'd255, 5'd1);
    run_mix(100, MIX_BALANCED);
    load_config(5'd31, 8'd128, 8'd0, 8'd255, 5'd0);
    run_mix(300, MIX_FALL);
  endtask

  task automatic test_crossed_bounds();
    load_config(5'd5, 8'd3, 8'd100, 8'd50, 5'd31);
    run_mix(100, MIX_BALANCED);
    load_config(5'd15, 8'd200, 8'd255, 8'd0, 5'd3);
    run_mix(60, MIX_NOISE);
  endtask

  task automatic test_backpressure();
    load_config(TOLERANCE_RST, DUTY_TOP_RST, VOLTAGE_MIN_RST, VOLTAGE_MAX_RST,
                HOLDOFF_RELOAD_RST);
    gaps_on = 1'b0;
    stall_requests <= stall_requests + 1;
    run_mix(40, MIX_BALANCED);
    drain_results();
    run_mix(40, MIX_NOISE);
    gaps_on = 1'b1;
  endtask

  task automatic test_random_mix();
    for (int p = 0; p < 3; p++) begin
      gaps_on = (p != 1);
      load_config(5'($urandom_range(0, 31)), 8'($urandom_range(0, 255)),
                  8'($urandom_range(0, 120)), 8'($urandom_range(100, 255)),
                  5'($urandom_range(0, 31)));
      run_mix(110, stim_mix_e'($urandom_range(0, 3)));
    end
    gaps_on = 1'b1;
  endtask

  initial begin
    rst_ni             = 1'b0;
    in_if.valid        = 1'b0;
    in_if.adc_sample   = '0;
    in_if.down_pressed = 1'b0;
    in_if.up_pressed   = 1'b0;
    cfg_if.valid       = 1'b0;
    cfg_if.index       = REG_TOLERANCE;
    cfg_if.data        = '0;
    cfg_tol            = TOLERANCE_RST;
    cfg_top            = DUTY_TOP_RST;
    cfg_vmin           = VOLTAGE_MIN_RST;
    cfg_vmax           = VOLTAGE_MAX_RST;
    cfg_reload         = HOLDOFF_RELOAD_RST;
    volt_set           = SET_VOLTAGE_RST;
    down_wait          = HOLDOFF_RST;
    up_wait            = HOLDOFF_RST;
    duty_lvl           = DUTY_LEVEL_RST;
    failures           = 0;
    steps_sent         = 0;
    results_checked    = 0;
    settings_loaded    = 0;
    lamp_seen          = '{0, 0, 0};
    burst_left         = 0;
    gaps_on            = 1'b1;
    down_held          = 1'b0;
    up_held            = 1'b0;
    stall_requests     = 0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_state();
    test_buttons_holdoff();
    test_duty_limits();
    test_voltage_sweep();
    test_crossed_bounds();
    test_backpressure();
    test_random_mix();
    drain_results();

    $display("tb: %0d control steps under %0d register settings, %0d results checked",
             steps_sent, settings_loaded, results_checked);
    $display("tb: window below %0d, inside %0d, above %0d; %0d mismatches",
             lamp_seen[0], lamp_seen[1], lamp_seen[2], failures);
    if (failures == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
sv/bvwr_pkg.sv
sv/bvwr_if.sv
sv/boost_voltage_window_regulator.sv
sv/bvwr_checker.sv
tb/tb_boost_voltage_window_regulator.sv
